FILE: hw/rtl/crc_generate_and_check_assert.svh
// Assertion macros for the programmable CRC block.
`ifndef CRC_GENERATE_AND_CHECK_ASSERT_SVH
`define CRC_GENERATE_AND_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/crc_pkg.sv
// Shared types, constants and shift functions for the programmable CRC block.
package crc_pkg;

  localparam int unsigned MaxGenLenDefault = 16;
  localparam int unsigned RemMaxW          = 15;
  localparam int unsigned GenBitsW         = 16;
  localparam int unsigned GenLenW          = 5;
  localparam int unsigned RsW              = 4;
  localparam int unsigned QueueDepth       = 4;
  localparam int unsigned ApbAddrW         = 3;
  localparam int unsigned ApbDataW         = 32;

  localparam logic [GenBitsW-1:0] GenBitsReset = 16'd11;
  localparam logic [GenLenW-1:0]  GenLenReset  = 5'd4;

  // register index, taken from paddr[2]
  localparam logic RegGenBits = 1'b0;
  localparam logic RegGenLen  = 1'b1;

  typedef logic [RemMaxW-1:0] rem_t;

  typedef struct packed {
    logic crc_run;   // generate-mode frame end: CRC bits follow
    logic out_bit;
    rem_t rem;
    logic ok;
  } crc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BackIdle,
    BackZero,
    BackEmit
  } back_state_e;

  // One shift-and-XOR step of an rs-bit remainder.
  function automatic rem_t crc_step(rem_t rem, logic din, rem_t poly, logic [RsW-1:0] rs);
    logic [RemMaxW:0] one_hot;
    rem_t             mask;
    rem_t             v;
    logic             top;
    one_hot = (RemMaxW + 1)'(1) << rs;
    mask    = rem_t'(one_hot - (RemMaxW + 1)'(1));
    top     = |(rem & rem_t'(one_hot >> 1));
    v       = {rem[RemMaxW-2:0], din};
    return (v ^ (top ? poly : '0)) & mask;
  endfunction

  function automatic logic crc_bit_at(rem_t v, logic [RsW-1:0] idx);
    return |(v & (rem_t'(1) << idx));
  endfunction

  // Remainder width from the length register: one less than the length clamped to [2, cap].
  function automatic logic [RsW-1:0] crc_eff_rs(logic [GenLenW-1:0] len, int unsigned cap);
    logic [GenLenW-1:0] l;
    l = len;
    if (l < GenLenW'(2)) l = GenLenW'(2);
    if (l > GenLenW'(cap)) l = GenLenW'(cap);
    return RsW'(l - GenLenW'(1));
  endfunction

endpackage

FILE: hw/rtl/crc_if.sv
// Valid/ready channel interfaces for the CRC block's request and result streams.
interface crc_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic data_bit;
  logic frame_end;

  modport source (output valid, output mode, output data_bit, output frame_end,
                  input ready);
  modport sink   (input valid, input mode, input data_bit, input frame_end,
                  output ready);
endinterface

interface crc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       out_bit;
  logic                       out_last;
  logic [crc_pkg::RemMaxW-1:0] remainder_value;
  logic                       check_ok;

  modport source (output valid, output out_bit, output out_last,
                  output remainder_value, output check_ok, input ready);
  modport sink   (input valid, input out_bit, input out_last,
                  input remainder_value, input check_ok, output ready);
endinterface

FILE: hw/rtl/crc_fifo.sv
// Short queue of classified requests between the CRC front and back ends.
module crc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crc_pkg::crc_entry_t entry_i,
  input  logic                pop_i,
  output crc_pkg::crc_entry_t head_o,
  output crc_pkg::q_status_t  status_o
);
  localparam int unsigned Depth = crc_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  crc_pkg::crc_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/crc_front.sv
// CRC front end: takes one bit a cycle while the queue has room; divides, classifies.
module crc_front #(
  parameter int unsigned RemW = crc_pkg::RemMaxW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  crc_in_if.sink                        in_i,
  input  crc_pkg::rem_t                 poly_i,
  input  logic [crc_pkg::RsW-1:0]       rs_i,
  input  crc_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output crc_pkg::crc_entry_t           entry_o
);
  logic [RemW-1:0] rem_q, rem_d;
  crc_pkg::rem_t   rem_step;

  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && in_i.ready;

  assign rem_step = crc_pkg::crc_step(crc_pkg::rem_t'(rem_q), in_i.data_bit, poly_i, rs_i);

  always_comb begin
    entry_o.crc_run = in_i.frame_end && !in_i.mode;
    entry_o.out_bit = !in_i.mode && in_i.data_bit;
    entry_o.rem     = in_i.frame_end ? rem_step : '0;
    entry_o.ok      = in_i.mode && in_i.frame_end && (rem_step == '0);
  end

  // remainder restarts from zero after every frame end
  always_comb begin
    rem_d = rem_q;
    if (push_o) begin
      rem_d = in_i.frame_end ? '0 : rem_step[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

endmodule

FILE: hw/rtl/crc_back.sv
// CRC back end: appends the zero bits, serialises the CRC and holds the result register.
module crc_back #(
  parameter int unsigned RemW = crc_pkg::RemMaxW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  crc_pkg::crc_entry_t     head_i,
  input  crc_pkg::q_status_t      q_status_i,
  output logic                    pop_o,
  input  crc_pkg::rem_t           poly_i,
  input  logic [crc_pkg::RsW-1:0] rs_i,
  crc_out_if.source               out_o
);
  localparam int unsigned CntW = $clog2(RemW + 1);

  crc_pkg::back_state_e state_q, state_d;
  logic [RemW-1:0]      work_q, work_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  crc_pkg::rem_t        work_ext;
  crc_pkg::rem_t        work_zero;

  logic                 out_valid_q;
  logic                 out_bit_q, out_last_q, check_ok_q;
  crc_pkg::rem_t        out_rem_q;

  logic                 can_load, load;
  logic                 beat_bit, beat_last, beat_ok;
  crc_pkg::rem_t        beat_rem;

  assign can_load  = !out_valid_q || out_o.ready;
  assign work_ext  = crc_pkg::rem_t'(work_q);
  assign work_zero = crc_pkg::crc_step(work_ext, 1'b0, poly_i, rs_i);

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    cnt_d     = cnt_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    beat_bit  = 1'b0;
    beat_last = 1'b0;
    beat_rem  = '0;
    beat_ok   = 1'b0;
    unique case (state_q)
      crc_pkg::BackIdle: begin
        if (!q_status_i.empty && can_load) begin
          pop_o    = 1'b1;
          load     = 1'b1;
          beat_bit = head_i.out_bit;
          if (head_i.crc_run) begin
            work_d  = head_i.rem[RemW-1:0];
            cnt_d   = CntW'(rs_i);
            state_d = crc_pkg::BackZero;
          end else begin
            beat_last = 1'b1;
            beat_rem  = head_i.rem;
            beat_ok   = head_i.ok;
          end
        end
      end
      crc_pkg::BackZero: begin
        // shift in the appended zeros, one per cycle
        work_d = work_zero[RemW-1:0];
        if (cnt_q == CntW'(1)) begin
          cnt_d   = CntW'(rs_i);
          state_d = crc_pkg::BackEmit;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      crc_pkg::BackEmit: begin
        if (can_load) begin
          load     = 1'b1;
          beat_bit = crc_pkg::crc_bit_at(work_ext, crc_pkg::RsW'(cnt_q - CntW'(1)));
          if (cnt_q == CntW'(1)) begin
            beat_last = 1'b1;
            beat_rem  = work_ext;
            state_d   = crc_pkg::BackIdle;
          end else begin
            cnt_d = cnt_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = crc_pkg::BackIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crc_pkg::BackIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (load) begin
      out_bit_q  <= beat_bit;
      out_last_q <= beat_last;
      out_rem_q  <= beat_rem;
      check_ok_q <= beat_ok;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_bit         = out_bit_q;
  assign out_o.out_last        = out_last_q;
  assign out_o.remainder_value = out_rem_q;
  assign out_o.check_ok        = check_ok_q;

endmodule

FILE: hw/rtl/crc_generate_and_check.sv
// Top level of the programmable bit-serial CRC generator and checker.
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    mode, data_bit, frame_end
//   out_o    out  valid / ready    out_bit, out_last, remainder_value, check_ok
//   apb      in   psel / penable   paddr, pwdata (write), prdata (read)
//
// One request is taken each cycle while the four-entry queue has room.
// Data-bit and check results pass through the queue and then the result register,
// one per cycle while the receiver is ready. A generate-mode frame end occupies the
// back end for the data bit, L-1 zero shifts through the back-end LFSR, then L-1 CRC
// bits; the front keeps taking requests meanwhile until the queue fills.
// Reset is asynchronous, active low; it clears the remainder, queue, FSM and
// result valid, and loads the generator registers with their defaults.
`include "crc_generate_and_check_assert.svh"

module crc_generate_and_check #(
  parameter int unsigned MAX_GEN_LEN = crc_pkg::MaxGenLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  crc_in_if.sink                        in_i,
  crc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [crc_pkg::ApbDataW-1:0]  pwdata,
  output logic [crc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);
  // longest generator actually supported, and the remainder width it needs
  localparam int unsigned GenCapHi = (MAX_GEN_LEN > crc_pkg::GenBitsW) ?
                                     crc_pkg::GenBitsW : MAX_GEN_LEN;
  localparam int unsigned GenCap   = (GenCapHi < 2) ? 2 : GenCapHi;
  localparam int unsigned RemW     = GenCap - 1;

  logic [crc_pkg::GenBitsW-1:0] gen_bits_q;
  logic [crc_pkg::GenLenW-1:0]  gen_len_q;
  logic                         cfg_wr;
  crc_pkg::rem_t                poly;
  logic [crc_pkg::RsW-1:0]      rs;

  logic                         push;
  logic                         pop;
  crc_pkg::crc_entry_t          entry;
  crc_pkg::crc_entry_t          head;
  crc_pkg::q_status_t           q_status;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_bits_q <= crc_pkg::GenBitsReset;
      gen_len_q  <= crc_pkg::GenLenReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        crc_pkg::RegGenBits: gen_bits_q <= pwdata[crc_pkg::GenBitsW-1:0];
        crc_pkg::RegGenLen:  gen_len_q  <= pwdata[crc_pkg::GenLenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      crc_pkg::RegGenBits: prdata = crc_pkg::ApbDataW'(gen_bits_q);
      crc_pkg::RegGenLen:  prdata = crc_pkg::ApbDataW'(gen_len_q);
      default:             prdata = '0;
    endcase
  end

  // leading generator bit is implied; only the low rs bits take part
  assign poly = gen_bits_q[crc_pkg::RemMaxW-1:0];
  assign rs   = crc_pkg::crc_eff_rs(gen_len_q, GenCap);

  // ---- front end: division and classification ----
  crc_front #(
    .RemW (RemW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .poly_i     (poly),
    .rs_i       (rs),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (entry)
  );

  // ---- queue ----
  crc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // ---- back end: CRC append and result register ----
  crc_back #(
    .RemW (RemW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .poly_i     (poly),
    .rs_i       (rs),
    .out_o      (out_o)
  );

  // ---- assertions ----
  `CRC_ASSERT_IMPLIES(a_accept_has_room, push, !q_status.full, "request accepted into full queue")
  `CRC_ASSERT_NEXT(a_push_fills, push && q_status.empty, !q_status.empty, "pushed request lost")
  `CRC_ASSERT_IMPLIES(a_ok_on_zero_rem, out_o.valid && out_o.check_ok, out_o.out_last && (out_o.remainder_value == '0), "check_ok with non-zero remainder")
  `CRC_ASSERT_IMPLIES(a_rem_on_last, out_o.valid && (out_o.remainder_value != '0), out_o.out_last, "remainder on a non-final result")

endmodule

FILE: tb/crc_stream_checker.sv
`timescale 1ns / 1ps
// Result checker for the CRC block: follows requests and register writes, predicts and compares.
module crc_stream_checker #(
  parameter int unsigned MaxGenLen = crc_pkg::MaxGenLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  crc_in_if                            req_mon,
  crc_out_if                           res_mon,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [crc_pkg::ApbAddrW-1:0] paddr,
  input  logic [crc_pkg::ApbDataW-1:0] pwdata,
  output int unsigned                  mismatches_o,
  output int unsigned                  awaiting_o,
  output int unsigned                  compared_o,
  output int unsigned                  clean_checks_o
);
  import crc_pkg::*;

  typedef struct packed {
    logic out_bit;
    logic out_last;
    rem_t remainder;
    logic ok;
  } crc_result_t;

  localparam int unsigned ReportLimit = 30;

  logic [GenBitsW-1:0] gen_bits;
  logic [GenLenW-1:0]  gen_len;
  rem_t                running_rem;
  crc_result_t         results_due[$];
  int unsigned         faults;
  int unsigned         compared;
  int unsigned         clean;

  // CRC width for a length register value, clamped to the supported range
  function automatic int unsigned rem_width(logic [GenLenW-1:0] len);
    int unsigned cap;
    int unsigned l;
    cap = (MaxGenLen > 16) ? 16 : ((MaxGenLen < 2) ? 2 : MaxGenLen);
    l   = len;
    if (l < 2) l = 2;
    if (l > cap) l = cap;
    return l - 1;
  endfunction

  // one shift-and-subtract step of an rs-bit remainder
  function automatic rem_t divide_bit(rem_t rem, logic din, int unsigned rs,
                                      logic [GenBitsW-1:0] poly);
    logic [RemMaxW:0] mask;
    logic [RemMaxW:0] v;
    mask = ~({(RemMaxW+1){1'b1}} << rs);
    v    = (({1'b0, rem} & mask) << 1) | {{RemMaxW{1'b0}}, din};
    if (v[rs]) v = v ^ ((poly & mask) | (mask + 1'b1));
    return rem_t'(v & mask);
  endfunction

  task automatic predict_request(logic mode, logic din, logic fend);
    int unsigned rs;
    rem_t        rem;
    logic        fin;
    rs  = rem_width(gen_len);
    rem = divide_bit(running_rem, din, rs, gen_bits);
    if (!fend) begin
      running_rem = rem;
      results_due.push_back(crc_result_t'{mode ? 1'b0 : din, 1'b1, '0, 1'b0});
    end else if (mode) begin
      running_rem = '0;
      results_due.push_back(crc_result_t'{1'b0, 1'b1, rem, rem == '0});
    end else begin
      // generate: flush rs zeros, then data bit and CRC bits MSB first
      running_rem = '0;
      for (int i = 0; i < rs; i++) rem = divide_bit(rem, 1'b0, rs, gen_bits);
      results_due.push_back(crc_result_t'{din, 1'b0, '0, 1'b0});
      for (int i = 0; i < rs; i++) begin
        fin = (i + 1 == rs);
        results_due.push_back(crc_result_t'{rem[rs-1-i], fin, fin ? rem : '0, 1'b0});
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    crc_result_t got;
    crc_result_t want;
    if (!rst_ni) begin
      gen_bits    = GenBitsReset;
      gen_len     = GenLenReset;
      running_rem = '0;
      faults      = 0;
      compared    = 0;
      clean       = 0;
      results_due.delete();
      mismatches_o   <= 0;
      awaiting_o     <= 0;
      compared_o     <= 0;
      clean_checks_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegGenBits) gen_bits = pwdata[GenBitsW-1:0];
        else                        gen_len  = pwdata[GenLenW-1:0];
      end

      if (res_mon.valid && res_mon.ready) begin
        got = crc_result_t'{res_mon.out_bit, res_mon.out_last,
                            res_mon.remainder_value, res_mon.check_ok};
        compared++;
        if (got.ok === 1'b1) clean++;
        if (results_due.size() == 0) begin
          faults++;
          if (faults <= ReportLimit)
            $display("%0t: unexpected result bit=%0d last=%0d rem=%h ok=%0d", $time,
                     got.out_bit, got.out_last, got.remainder, got.ok);
        end else begin
          want = results_due.pop_front();
          if (got.out_bit !== want.out_bit || got.out_last !== want.out_last ||
              got.remainder !== want.remainder || got.ok !== want.ok) begin
            faults++;
            if (faults <= ReportLimit)
              $display("%0t: mismatch expected bit=%0d last=%0d rem=%h ok=%0d, got bit=%0d last=%0d rem=%h ok=%0d",
                       $time, want.out_bit, want.out_last, want.remainder, want.ok,
                       got.out_bit, got.out_last, got.remainder, got.ok);
          end
        end
      end

      if (req_mon.valid && req_mon.ready)
        predict_request(req_mon.mode, req_mon.data_bit, req_mon.frame_end);

      mismatches_o   <= faults;
      awaiting_o     <= results_due.size();
      compared_o     <= compared;
      clean_checks_o <= clean;
    end
  end

endmodule

FILE: tb/crc_generate_and_check_tb.sv
`timescale 1ns / 1ps
// Testbench top for the CRC block: clock, reset, requests, register writes and the verdict.
module crc_generate_and_check_tb;
  import crc_pkg::*;

  localparam int unsigned TimeoutCycles = 2000;
  // covers the longest back-end run and the result path, with margin
  localparam int unsigned SettleCycles  = 40;
  localparam int unsigned RandomItems   = 230;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  crc_in_if  req_bus ();
  crc_out_if res_bus ();

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned compared;
  int unsigned clean_checks;

  int unsigned requests_sent;
  int unsigned gen_frames;
  int unsigned chk_frames;
  int unsigned settings_used;
  int unsigned idle_cycles;
  int unsigned stall_left;

  // what the stimulus believes is programmed, for building valid check frames
  logic [GenBitsW-1:0] poly_now;
  int unsigned         rem_bits;

  // idle-free stretches on either side
  bit send_quiet;
  bit take_quiet;

  crc_generate_and_check uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_bus),
    .out_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crc_stream_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_bus),
    .res_mon        (res_bus),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches_o   (mismatches),
    .awaiting_o     (awaiting),
    .compared_o     (compared),
    .clean_checks_o (clean_checks)
  );

  always #1 clk_i = ~clk_i;

  // Result side: after each taken result, outside a quiet stretch, ready may drop for a random pause.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned pause;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      res_bus.ready <= (stall_left == 1);
    end else if (res_bus.valid && res_bus.ready && !take_quiet) begin
      pause          = $urandom_range(0, 4);
      stall_left    <= pause;
      res_bus.ready <= (pause == 0);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Watchdog: any request, result or register access counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= TimeoutCycles) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results still due",
               TimeoutCycles, awaiting);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Data followed by its CRC, as one right-aligned vector of n + rs bits.
  function automatic logic [31:0] with_crc(logic [31:0] data, int unsigned n,
                                           logic [15:0] poly, int unsigned rs);
    logic [31:0] msg;
    logic [16:0] acc;
    logic [16:0] divisor;
    msg     = data << rs;
    divisor = {1'b0, poly & ~(16'hFFFF << rs)} | (17'd1 << rs);
    acc     = '0;
    for (int i = n + rs - 1; i >= 0; i--) begin
      acc = {acc[15:0], msg[i]};
      if (acc[rs]) acc = acc ^ divisor;
    end
    return msg | 32'(acc);
  endfunction

  // Two-phase APB write; an idle wait after it keeps psel from toggling twice in a step.
  task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, wait for every predicted result, then let the back end go quiet.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (awaiting != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_generator(logic [GenBitsW-1:0] bits, logic [GenLenW-1:0] len);
    wait_for_results();
    apb_write({RegGenBits, 2'b00}, ApbDataW'(bits));
    apb_write({RegGenLen, 2'b00}, ApbDataW'(len));
    poly_now = bits;
    if (len < 2)                      rem_bits = 1;
    else if (len > MaxGenLenDefault)  rem_bits = MaxGenLenDefault - 1;
    else                              rem_bits = len - 1;
    settings_used++;
  endtask

  // One request; a random gap first unless the sender is in a quiet stretch.
  task automatic send_bit(logic mode, logic din, logic fend);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.mode      <= mode;
    req_bus.data_bit  <= din;
    req_bus.frame_end <= fend;
    do @(posedge clk_i); while (!req_bus.ready);
    requests_sent++;
  endtask

  // Bits and modes go out MSB first; the mode of the last bit names the frame.
  task automatic send_frame(logic [31:0] bits, int unsigned n, logic [31:0] modes);
    for (int i = n - 1; i >= 0; i--) send_bit(modes[i], bits[i], i == 0);
    if (modes[0]) chk_frames++;
    else          gen_frames++;
  endtask

  initial begin
    int unsigned    kind;
    int unsigned    n;
    int unsigned    frames;
    logic [31:0]    data;
    logic [31:0]    framed;
    logic [GenLenW-1:0] len;

    rst_ni            = 1'b0;
    req_bus.valid     = 1'b0;
    req_bus.mode      = 1'b0;
    req_bus.data_bit  = 1'b0;
    req_bus.frame_end = 1'b0;
    res_bus.ready     = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    idle_cycles       = 0;
    stall_left        = 0;
    send_quiet        = 1'b0;
    take_quiet        = 1'b0;
    requests_sent     = 0;
    gen_frames        = 0;
    chk_frames        = 0;
    settings_used     = 1;
    frames            = 0;
    poly_now          = GenBitsReset;
    rem_bits          = GenLenReset - 1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset generator 1011: generate a frame, then check it with its CRC (clean)
    send_frame(32'b1011, 4, 32'h0);
    send_frame(with_crc(32'b1011, 4, poly_now, rem_bits), 4 + rem_bits, 32'hFFFF_FFFF);

    // widest generator, all ones: single-bit frames, longest CRC run
    set_generator(16'hFFFF, 5'd16);
    send_frame(32'b1, 1, 32'h0);
    send_frame(32'b0, 1, 32'hFFFF_FFFF);

    // length below the minimum, all-zero generator bits
    set_generator(16'h0000, 5'd0);
    send_frame(32'b11, 2, 32'h0);

    // length above the limit; mode changes mid-frame, ending in each mode
    set_generator(16'hA5C3, 5'd31);
    send_frame(32'b101, 3, 32'b010);
    send_frame(32'b011, 3, 32'b101);

    // --- random, until the overall request count is reached ---
    while (requests_sent < RandomItems) begin
      if (frames % 4 == 3) begin
        if (settings_used % 5 == 0)         len = 5'd2;
        else if ($urandom_range(0, 3) == 0) len = GenLenW'($urandom_range(0, 31));
        else                                len = GenLenW'($urandom_range(2, 16));
        set_generator(GenBitsW'($urandom()), len);
      end
      frames++;
      send_quiet = ($urandom_range(0, 4) == 0);
      take_quiet = ($urandom_range(0, 4) == 0);

      kind = $urandom_range(0, 9);
      n    = $urandom_range(1, 10);
      data = $urandom() & ((32'd1 << n) - 1);
      if (kind <= 5) begin
        // transmit, then receive the same frame, sometimes with one bit flipped
        send_frame(data, n, 32'h0);
        framed = with_crc(data, n, poly_now, rem_bits);
        if ($urandom_range(0, 3) == 0)
          framed = framed ^ (32'd1 << $urandom_range(0, n + rem_bits - 1));
        send_frame(framed, n + rem_bits, 32'hFFFF_FFFF);
      end else if (kind == 6) begin
        send_frame(data, n, 32'h0);
      end else if (kind == 7) begin
        // noise into the checker
        send_frame(data, n, 32'hFFFF_FFFF);
      end else if (kind == 8) begin
        send_frame(data, n, $urandom());
      end else begin
        // hold off until the pipe is empty before the next frame
        wait_for_results();
        send_frame(data, n, 32'h0);
      end
    end

    wait_for_results();

    $display("Covered %0d requests: %0d generate and %0d check frames over %0d generator settings.",
             requests_sent, gen_frames, chk_frames, settings_used);
    $display("%0d results compared, %0d check frames reported a zero remainder.",
             compared, clean_checks);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
